// ===== hdl/lfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfd_pkg
// Types and constants shared by the line-following drive state machine.
// ----------------------------------------------------------------------------
package lfd_pkg;

    localparam int NOW_BITS = 32;
    localparam int SPD_BITS = 7;
    localparam int TMO_BITS = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int GATE_MS = 20;

    typedef logic [SPD_BITS-1:0]      spd_cfg_t;
    typedef logic [TMO_BITS-1:0]      tmo_cfg_t;
    typedef logic signed [8:0]        speed_t;
    typedef logic [2:0]               cfg_addr_t;
    typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;
    typedef logic [NOW_BITS-1:0]      now_t;

    typedef enum logic [3:0] {
        ST_READY    = 4'd0,
        ST_STRAIGHT = 4'd1,
        ST_LSLIGHT  = 4'd2,
        ST_RSLIGHT  = 4'd3,
        ST_LMOD     = 4'd4,
        ST_RMOD     = 4'd5,
        ST_LSHARP   = 4'd6,
        ST_RSHARP   = 4'd7,
        ST_CROSS    = 4'd8,
        ST_LOST     = 4'd9,
        ST_RECOVER  = 4'd10,
        ST_ALLBLACK = 4'd11,
        ST_FINISH   = 4'd12
    } state_t;

    // register indexes
    localparam cfg_addr_t CFG_STRAIGHT_SPEED = 3'd0;
    localparam cfg_addr_t CFG_SLIGHT_SPEED   = 3'd1;
    localparam cfg_addr_t CFG_MODERATE_SPEED = 3'd2;
    localparam cfg_addr_t CFG_SHARP_SPEED    = 3'd3;
    localparam cfg_addr_t CFG_CROSS_SPEED    = 3'd4;
    localparam cfg_addr_t CFG_RECOVERY_SPEED = 3'd5;
    localparam cfg_addr_t CFG_RECOVERY_TMO   = 3'd6;
    localparam cfg_addr_t CFG_CROSS_TMO      = 3'd7;

    localparam spd_cfg_t RST_STRAIGHT_SPEED = 7'd50;
    localparam spd_cfg_t RST_SLIGHT_SPEED   = 7'd35;
    localparam spd_cfg_t RST_MODERATE_SPEED = 7'd25;
    localparam spd_cfg_t RST_SHARP_SPEED    = 7'd15;
    localparam spd_cfg_t RST_CROSS_SPEED    = 7'd45;
    localparam spd_cfg_t RST_RECOVERY_SPEED = 7'd40;
    localparam tmo_cfg_t RST_RECOVERY_TMO   = 16'd10000;
    localparam tmo_cfg_t RST_CROSS_TMO      = 16'd200;

    localparam spd_cfg_t DIFF_SLIGHT   = 7'd25;
    localparam spd_cfg_t DIFF_MODERATE = 7'd40;
    localparam spd_cfg_t DIFF_SHARP    = 7'd50;
    localparam spd_cfg_t DIFF_RECOVER  = 7'd20;

    // sensor pattern {left, center, right}
    localparam logic [2:0] PAT_NONE   = 3'b000;
    localparam logic [2:0] PAT_RIGHT  = 3'b001;
    localparam logic [2:0] PAT_CENTER = 3'b010;
    localparam logic [2:0] PAT_CR     = 3'b011;
    localparam logic [2:0] PAT_LEFT   = 3'b100;
    localparam logic [2:0] PAT_LR     = 3'b101;
    localparam logic [2:0] PAT_LC     = 3'b110;
    localparam logic [2:0] PAT_ALL    = 3'b111;

    localparam speed_t SPEED_ZERO = 9'sd0;

    function automatic speed_t spd_plus(spd_cfg_t base, spd_cfg_t diff);
        spd_plus = $signed({2'b00, base}) + $signed({2'b00, diff});
    endfunction

    function automatic speed_t spd_minus(spd_cfg_t base, spd_cfg_t diff);
        spd_minus = $signed({2'b00, base}) - $signed({2'b00, diff});
    endfunction

    function automatic speed_t spd_flat(spd_cfg_t base);
        spd_flat = $signed({2'b00, base});
    endfunction

endpackage

// ===== hdl/line_follow_drive_fsm.sv =====
// ----------------------------------------------------------------------------
// line_follow_drive_fsm
// Polls the line sensors on a 20 ms gate and steers two signed wheel targets.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | now_ms, line_l/c/r, auto, e-stop
//  m_      | out       | m_valid / m_ready | left/right wheel, state, no-line, acc
//  cfg_    | in        | cfg_we            | cfg_addr, cfg_wdata (16 bit)
//
//  One item per cycle sustained while the result is not stalled; an item passes
//  the input register, then the result register. The state update and the result
//  are formed combinationally between those registers.
//  Reset (aresetn low, synchronous) empties both registers and restores the
//  register defaults; no clearing pass.
//  A stalled result holds; s_ready stays high while the input register is empty or
//  can move forward into the result register.
// ----------------------------------------------------------------------------
module line_follow_drive_fsm #(
    parameter int TIME_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_we,
    input  lfd_pkg::cfg_addr_t  cfg_addr,
    input  lfd_pkg::cfg_data_t  cfg_wdata,

    input  logic                s_valid,
    output logic                s_ready,
    input  lfd_pkg::now_t       s_now_ms,
    input  logic                s_line_left,
    input  logic                s_line_center,
    input  logic                s_line_right,
    input  logic                s_auto_mode,
    input  logic                s_emergency_stop,

    output logic                m_valid,
    input  logic                m_ready,
    output lfd_pkg::speed_t     m_left_wheel,
    output lfd_pkg::speed_t     m_right_wheel,
    output logic [3:0]          m_track_state,
    output logic                m_no_line,
    output logic                m_accepted
);
    import lfd_pkg::*;

    typedef logic [TIME_BITS-1:0] tstamp_t;

    // configuration
    spd_cfg_t straight_speed_reg, slight_speed_reg, moderate_speed_reg;
    spd_cfg_t sharp_speed_reg, cross_speed_reg, recovery_speed_reg;
    tmo_cfg_t recovery_tmo_reg, cross_tmo_reg;

    // input register
    logic       in_valid_reg;
    now_t       in_now_reg;
    logic [2:0] in_pat_reg;
    logic       in_auto_reg;
    logic       in_estop_reg;

    // tracking state
    state_t  state_reg, state_next;
    tstamp_t entry_reg, entry_next;
    tstamp_t cross_entry_reg, cross_entry_next;
    tstamp_t last_poll_reg, last_poll_next;
    logic    rtl_reg, rtl_next;
    speed_t  left_reg, left_next;
    speed_t  right_reg, right_next;
    logic    lost_reg, lost_next;

    // result register
    logic    out_valid_reg, out_valid_next;
    speed_t  out_left_reg, out_right_reg;
    state_t  out_state_reg;
    logic    out_lost_reg, out_acc_reg;

    logic    advance, gate, fire, drive;
    tstamp_t now_t_w, poll_el, cross_el, rec_el;
    logic    left_turn;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign now_t_w  = TIME_BITS'(in_now_reg);
    assign poll_el  = now_t_w - last_poll_reg;
    assign cross_el = now_t_w - cross_entry_reg;
    assign rec_el   = now_t_w - entry_reg;
    assign gate     = poll_el >= TIME_BITS'(GATE_MS);
    assign fire     = advance && gate;
    assign drive    = in_auto_reg && !in_estop_reg;
    assign left_turn = (state_reg == ST_LSLIGHT) || (state_reg == ST_LMOD) ||
                       (state_reg == ST_LSHARP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            straight_speed_reg <= RST_STRAIGHT_SPEED;
            slight_speed_reg   <= RST_SLIGHT_SPEED;
            moderate_speed_reg <= RST_MODERATE_SPEED;
            sharp_speed_reg    <= RST_SHARP_SPEED;
            cross_speed_reg    <= RST_CROSS_SPEED;
            recovery_speed_reg <= RST_RECOVERY_SPEED;
            recovery_tmo_reg   <= RST_RECOVERY_TMO;
            cross_tmo_reg      <= RST_CROSS_TMO;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_STRAIGHT_SPEED: straight_speed_reg <= cfg_wdata[SPD_BITS-1:0];
                CFG_SLIGHT_SPEED:   slight_speed_reg   <= cfg_wdata[SPD_BITS-1:0];
                CFG_MODERATE_SPEED: moderate_speed_reg <= cfg_wdata[SPD_BITS-1:0];
                CFG_SHARP_SPEED:    sharp_speed_reg    <= cfg_wdata[SPD_BITS-1:0];
                CFG_CROSS_SPEED:    cross_speed_reg    <= cfg_wdata[SPD_BITS-1:0];
                CFG_RECOVERY_SPEED: recovery_speed_reg <= cfg_wdata[SPD_BITS-1:0];
                CFG_RECOVERY_TMO:   recovery_tmo_reg   <= cfg_wdata[TMO_BITS-1:0];
                CFG_CROSS_TMO:      cross_tmo_reg      <= cfg_wdata[TMO_BITS-1:0];
                default: ;
            endcase
        end
    end

    // next state, entry times and recovery direction
    always_comb begin
        state_next       = state_reg;
        rtl_next         = rtl_reg;
        cross_entry_next = cross_entry_reg;
        last_poll_next   = last_poll_reg;
        lost_next        = lost_reg;
        if (fire) begin
            last_poll_next = now_t_w;
            if (!drive) begin
                state_next = ST_READY;
            end else begin
                lost_next = (in_pat_reg == PAT_NONE);
                unique case (state_reg) inside
                    ST_READY: begin
                        state_next = ST_STRAIGHT;
                    end
                    ST_STRAIGHT: begin
                        case (in_pat_reg)
                            PAT_LC:    state_next = ST_LSLIGHT;
                            PAT_CR:    state_next = ST_RSLIGHT;
                            PAT_LEFT:  state_next = ST_LMOD;
                            PAT_RIGHT: state_next = ST_RMOD;
                            PAT_NONE: begin
                                state_next = ST_LOST;
                                rtl_next   = 1'b0;
                            end
                            PAT_ALL: begin
                                state_next       = ST_CROSS;
                                cross_entry_next = now_t_w;
                            end
                            default: ;
                        endcase
                    end
                    ST_LSLIGHT, ST_RSLIGHT, ST_LMOD, ST_RMOD, ST_LSHARP, ST_RSHARP: begin
                        if (in_pat_reg == PAT_CENTER) begin
                            state_next = ST_STRAIGHT;
                        end else if (in_pat_reg == PAT_NONE) begin
                            state_next = ST_LOST;
                            rtl_next   = left_turn;
                        end else if (in_pat_reg == PAT_ALL) begin
                            state_next       = ST_CROSS;
                            cross_entry_next = now_t_w;
                        end else if (state_reg == ST_LSLIGHT && in_pat_reg == PAT_LEFT) begin
                            state_next = ST_LMOD;
                        end else if (state_reg == ST_LMOD && in_pat_reg == PAT_LC) begin
                            state_next = ST_LSLIGHT;
                        end else if (state_reg == ST_RSLIGHT && in_pat_reg == PAT_RIGHT) begin
                            state_next = ST_RMOD;
                        end else if (state_reg == ST_RMOD && in_pat_reg == PAT_CR) begin
                            state_next = ST_RSLIGHT;
                        end
                    end
                    ST_CROSS: begin
                        if (in_pat_reg != PAT_ALL &&
                            (cross_el > TIME_BITS'(cross_tmo_reg) || in_pat_reg != PAT_NONE))
                            state_next = ST_STRAIGHT;
                    end
                    ST_LOST: begin
                        state_next = ST_RECOVER;
                    end
                    ST_RECOVER: begin
                        if (in_pat_reg != PAT_NONE) state_next = ST_STRAIGHT;
                    end
                    ST_ALLBLACK: begin
                        if (in_pat_reg != PAT_ALL) state_next = ST_STRAIGHT;
                    end
                    ST_FINISH: ;
                    default: ;
                endcase
            end
        end
        entry_next = (state_next != state_reg) ? now_t_w : entry_reg;
    end

    // wheel targets
    always_comb begin
        left_next  = left_reg;
        right_next = right_reg;
        if (fire) begin
            if (!drive) begin
                if (state_reg != ST_READY) begin
                    left_next  = SPEED_ZERO;
                    right_next = SPEED_ZERO;
                end
            end else begin
                unique case (state_reg)
                    ST_STRAIGHT: begin
                        // center-only and left+right patterns keep driving straight
                        if (in_pat_reg == PAT_CENTER || in_pat_reg == PAT_LR) begin
                            left_next  = spd_flat(straight_speed_reg);
                            right_next = spd_flat(straight_speed_reg);
                        end
                    end
                    ST_LSLIGHT: begin
                        left_next  = spd_minus(slight_speed_reg, DIFF_SLIGHT);
                        right_next = spd_plus(slight_speed_reg, DIFF_SLIGHT);
                    end
                    ST_RSLIGHT: begin
                        left_next  = spd_plus(slight_speed_reg, DIFF_SLIGHT);
                        right_next = spd_minus(slight_speed_reg, DIFF_SLIGHT);
                    end
                    ST_LMOD: begin
                        left_next  = spd_minus(moderate_speed_reg, DIFF_MODERATE);
                        right_next = spd_plus(moderate_speed_reg, DIFF_MODERATE);
                    end
                    ST_RMOD: begin
                        left_next  = spd_plus(moderate_speed_reg, DIFF_MODERATE);
                        right_next = spd_minus(moderate_speed_reg, DIFF_MODERATE);
                    end
                    ST_LSHARP: begin
                        left_next  = spd_minus(sharp_speed_reg, DIFF_SHARP);
                        right_next = spd_plus(sharp_speed_reg, DIFF_SHARP);
                    end
                    ST_RSHARP: begin
                        left_next  = spd_plus(sharp_speed_reg, DIFF_SHARP);
                        right_next = spd_minus(sharp_speed_reg, DIFF_SHARP);
                    end
                    ST_CROSS: begin
                        left_next  = spd_flat(cross_speed_reg);
                        right_next = spd_flat(cross_speed_reg);
                    end
                    ST_RECOVER: begin
                        if (in_pat_reg == PAT_NONE && rec_el > TIME_BITS'(recovery_tmo_reg)) begin
                            left_next  = SPEED_ZERO;
                            right_next = SPEED_ZERO;
                        end else if (rtl_reg) begin
                            left_next  = spd_minus(recovery_speed_reg, DIFF_RECOVER);
                            right_next = spd_plus(recovery_speed_reg, DIFF_RECOVER);
                        end else begin
                            left_next  = spd_plus(recovery_speed_reg, DIFF_RECOVER);
                            right_next = spd_minus(recovery_speed_reg, DIFF_RECOVER);
                        end
                    end
                    ST_ALLBLACK: begin
                        left_next  = spd_flat(straight_speed_reg);
                        right_next = spd_flat(straight_speed_reg);
                    end
                    ST_FINISH: begin
                        left_next  = SPEED_ZERO;
                        right_next = SPEED_ZERO;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        if (advance)      out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
        else              out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= ST_READY;
            entry_reg       <= '0;
            cross_entry_reg <= '0;
            last_poll_reg   <= '0;
            rtl_reg         <= 1'b0;
            left_reg        <= SPEED_ZERO;
            right_reg       <= SPEED_ZERO;
            lost_reg        <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            out_valid_reg   <= out_valid_next;
            state_reg       <= state_next;
            entry_reg       <= entry_next;
            cross_entry_reg <= cross_entry_next;
            last_poll_reg   <= last_poll_next;
            rtl_reg         <= rtl_next;
            left_reg        <= left_next;
            right_reg       <= right_next;
            lost_reg        <= lost_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_now_reg   <= s_now_ms;
            in_pat_reg   <= {s_line_left, s_line_center, s_line_right};
            in_auto_reg  <= s_auto_mode;
            in_estop_reg <= s_emergency_stop;
        end
        if (advance) begin
            out_left_reg  <= left_next;
            out_right_reg <= right_next;
            out_state_reg <= state_next;
            out_lost_reg  <= lost_next;
            out_acc_reg   <= gate;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_left_wheel  = out_left_reg;
    assign m_right_wheel = out_right_reg;
    assign m_track_state = out_state_reg;
    assign m_no_line     = out_lost_reg;
    assign m_accepted    = out_acc_reg;

endmodule

// ===== hdl/lfd_checker.sv =====
// ----------------------------------------------------------------------------
// lfd_checker
// Port-level checks for the line-following drive state machine.
// ----------------------------------------------------------------------------
module lfd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input lfd_pkg::speed_t     m_left_wheel,
    input lfd_pkg::speed_t     m_right_wheel,
    input logic [3:0]          m_track_state,
    input logic                m_no_line
);
    import lfd_pkg::*;

    // no result comes out of reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("stalled result dropped");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_left_wheel) && $stable(m_right_wheel)
                                && $stable(m_track_state))
        else $error("stalled result changed");

    // ready only ever follows reset or a stop, both of which zero the wheels
    a_ready_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_track_state == ST_READY |-> m_left_wheel == SPEED_ZERO &&
                                                 m_right_wheel == SPEED_ZERO)
        else $error("wheels driven in ready state");

    // the lost state is only entered on a poll that saw no line
    a_lost_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_track_state == ST_LOST |-> m_no_line)
        else $error("lost state without no-line flag");

endmodule

bind line_follow_drive_fsm lfd_checker u_lfd_checker (.*);
